// File: rtl/core/nps_pkg.sv
// ----------------------------------------------------------------------------
// nps_pkg
// Shared types and constants for the 3D nearest point search block.
// ----------------------------------------------------------------------------
`default_nettype none

package nps_pkg;

    // Default sizes of the point store and of one coordinate.
    localparam int DEF_MAX_POINTS = 1024;
    localparam int DEF_COORD_BITS = 16;

    // Fixed field widths.
    localparam int SLOT_W      = 10;
    localparam int COUNT_W     = 11;
    localparam int TAG_W       = 16;
    localparam int REG_INDEX_W = 1;

    // Item operation codes.
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // Configuration register indexes.
    localparam logic [REG_INDEX_W-1:0] REG_POINT_COUNT = 1'd0;
    localparam logic [REG_INDEX_W-1:0] REG_MAX_DIST    = 1'd1;

    // Control that travels with one point through the distance pipeline.
    typedef struct packed {
        logic valid;
        logic last;
    } nps_ctl_t;

endpackage

`default_nettype wire

// File: rtl/core/nps_if.sv
// ----------------------------------------------------------------------------
// nps_item_if / nps_result_if
// Valid/ready channels for input items and search results.
// ----------------------------------------------------------------------------
`default_nettype none

interface nps_item_if
    import nps_pkg::*;
#(
    parameter int COORD_BITS = DEF_COORD_BITS
) ();
    logic                         valid;
    logic                         ready;
    logic                         opcode;
    logic        [SLOT_W-1:0]     slot;
    logic signed [COORD_BITS-1:0] coord_x;
    logic signed [COORD_BITS-1:0] coord_y;
    logic signed [COORD_BITS-1:0] coord_z;
    logic        [TAG_W-1:0]      query_tag;

    modport source (
        output valid, opcode, slot, coord_x, coord_y, coord_z, query_tag,
        input  ready
    );
    modport sink (
        input  valid, opcode, slot, coord_x, coord_y, coord_z, query_tag,
        output ready
    );
endinterface

interface nps_result_if
    import nps_pkg::*;
#(
    parameter int COORD_BITS = DEF_COORD_BITS
) ();
    logic                    valid;
    logic                    ready;
    logic [TAG_W-1:0]        tag_out;
    logic [SLOT_W-1:0]       nearest_slot;
    logic [2*COORD_BITS+1:0] best_distance_sq;
    logic                    within_limit;
    logic                    store_empty;

    modport source (
        output valid, tag_out, nearest_slot, best_distance_sq, within_limit, store_empty,
        input  ready
    );
    modport sink (
        input  valid, tag_out, nearest_slot, best_distance_sq, within_limit, store_empty,
        output ready
    );
endinterface

`default_nettype wire

// File: rtl/core/nps_store.sv
// ----------------------------------------------------------------------------
// nps_store
// Target point memory: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module nps_store
    import nps_pkg::*;
#(
    parameter int DEPTH  = DEF_MAX_POINTS,
    parameter int WIDTH  = 3 * DEF_COORD_BITS,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] raddr,
    output      logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/nps_dist_unit.sv
// ----------------------------------------------------------------------------
// nps_dist_unit
// Pipelined squared Euclidean distance, one stored point per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module nps_dist_unit
    import nps_pkg::*;
#(
    parameter int COORD_BITS = DEF_COORD_BITS
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic signed [COORD_BITS-1:0] query_x,
    input  wire logic signed [COORD_BITS-1:0] query_y,
    input  wire logic signed [COORD_BITS-1:0] query_z,
    input  wire nps_ctl_t                     issue_ctl,
    input  wire logic [3*COORD_BITS-1:0]      point,
    output      nps_ctl_t                     dist_ctl,
    output      logic [2*COORD_BITS+1:0]      dist_sq
);

    localparam int C = COORD_BITS;

    // The control of an issued read is registered once, so it lines up with the memory data.
    nps_ctl_t ctl0_reg, ctl1_reg, ctl2_reg, ctl3_reg;

    logic signed [C:0] dx, dy, dz;
    logic [C-1:0]      ax_reg, ay_reg, az_reg;
    logic [2*C-1:0]    sx_reg, sy_reg, sz_reg;
    logic [2*C+1:0]    sum_reg;

    function automatic logic [C-1:0] mag(input logic signed [C:0] d);
        logic signed [C:0] n;
        n = -d;
        return d[C] ? n[C-1:0] : d[C-1:0];
    endfunction

    always_comb
    begin
        dx = {query_x[C-1], query_x} - {point[3*C-1], point[3*C-1:2*C]};
        dy = {query_y[C-1], query_y} - {point[2*C-1], point[2*C-1:C]};
        dz = {query_z[C-1], query_z} - {point[C-1], point[C-1:0]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl0_reg <= '0;
            ctl1_reg <= '0;
            ctl2_reg <= '0;
            ctl3_reg <= '0;
        end
        else
        begin
            ctl0_reg <= issue_ctl;
            ctl1_reg <= ctl0_reg;
            ctl2_reg <= ctl1_reg;
            ctl3_reg <= ctl2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        ax_reg  <= mag(dx);
        ay_reg  <= mag(dy);
        az_reg  <= mag(dz);
        sx_reg  <= ax_reg * ax_reg;
        sy_reg  <= ay_reg * ay_reg;
        sz_reg  <= az_reg * az_reg;
        sum_reg <= {2'b00, sx_reg} + {2'b00, sy_reg} + {2'b00, sz_reg};
    end

    assign dist_ctl = ctl3_reg;
    assign dist_sq  = sum_reg;

endmodule

`default_nettype wire

// File: rtl/core/nearest_point_search_3d.sv
// ----------------------------------------------------------------------------
// nearest_point_search_3d
// Brute-force nearest neighbor search over a store of 3D target points.
// ----------------------------------------------------------------------------
// Usage:
// The item channel carries two kinds of transfer. A load (opcode 0) writes
// one point into the given slot of the store; a slot beyond the store is
// dropped. A query (opcode 1) scans the first point_count slots (clamped to
// the store size) and yields one transfer on the result channel: the tag,
// the nearest slot (lowest slot on a tie), the squared distance, whether it
// is not above max_distance_sq, and whether the store was empty.
// A query of n points reads one point per cycle from the store through a
// shared distance pipeline; its result enters the output register once the
// last distance is out and the register is free; an empty store skips the
// scan. The block takes no item while a query is in flight, so the next item
// can transfer only once its result is registered. The store's single read
// port sets the pace of one point per cycle.
// The result sits in an output register. When the receiver stalls, the block
// still accepts the next item; a later query holds its finished result until
// the output register frees up. Reset clears the control state and the
// configuration registers (point_count 0, limit 0.02 squared); the store
// contents stay undefined. The user writes configuration through wr_en,
// reg_index and wr_data only while idle; the block does not enforce it.
// ----------------------------------------------------------------------------
`default_nettype none

module nearest_point_search_3d
    import nps_pkg::*;
#(
    parameter int MAX_POINTS = DEF_MAX_POINTS,
    parameter int COORD_BITS = DEF_COORD_BITS
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    nps_item_if.sink                     item,
    nps_result_if.source                 result,
    input  wire logic                    wr_en,
    input  wire logic [REG_INDEX_W-1:0]  reg_index,
    input  wire logic [2*COORD_BITS+1:0] wr_data
);

    localparam int DIST_W = 2 * COORD_BITS + 2;
    localparam int ADDR_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CNT_W  = $clog2(MAX_POINTS + 1);

    // Largest possible squared distance, reported for an empty store.
    localparam logic [63:0] COORD_MAX = (64'd1 << COORD_BITS) - 64'd1;
    localparam logic [DIST_W-1:0] DIST_MAX = DIST_W'(64'd3 * COORD_MAX * COORD_MAX);

    // Reset limit is 0.02 squared in units of one LSB squared, rounded.
    localparam logic [DIST_W-1:0] LIMIT_RESET =
        DIST_W'(((64'd1 << (2 * COORD_BITS - 2)) * 64'd4 + 64'd5000) / 64'd10000);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_FINISH
    } state_t;

    state_t state_reg;

    // Configuration registers.
    logic [COUNT_W-1:0] point_count_reg;
    logic [DIST_W-1:0]  limit_reg;

    // Query context.
    logic signed [COORD_BITS-1:0] qx_reg, qy_reg, qz_reg;
    logic [TAG_W-1:0]             tag_reg;
    logic [CNT_W-1:0]             n_reg;
    logic [ADDR_W-1:0]            addr_reg;
    logic [ADDR_W-1:0]            cmp_idx_reg;
    logic [DIST_W-1:0]            best_reg;
    logic [ADDR_W-1:0]            best_idx_reg;
    logic                         empty_reg;

    // Output register.
    logic               res_valid_reg;
    logic [TAG_W-1:0]   res_tag_reg;
    logic [SLOT_W-1:0]  res_slot_reg;
    logic [DIST_W-1:0]  res_dist_reg;
    logic               res_within_reg;
    logic               res_empty_reg;

    logic                      item_fire;
    logic                      load_we;
    logic [CNT_W-1:0]          n_clamped;
    nps_ctl_t                  issue_ctl;
    nps_ctl_t                  dist_ctl;
    logic [DIST_W-1:0]         dist_sq;
    logic [3*COORD_BITS-1:0]   rdata;
    logic                      dist_better;
    logic                      out_free;

    assign item.ready = (state_reg == ST_IDLE);
    assign item_fire  = item.valid && item.ready;

    // Loads outside the store are dropped.
    assign load_we = item_fire && (item.opcode == OP_LOAD)
                     && (32'(item.slot) < 32'(MAX_POINTS));

    always_comb
    begin
        if (32'(point_count_reg) > 32'(MAX_POINTS))
        begin
            n_clamped = CNT_W'(MAX_POINTS);
        end
        else
        begin
            n_clamped = CNT_W'(point_count_reg);
        end
    end

    // One store read is issued per cycle while scanning.
    always_comb
    begin
        issue_ctl.valid = (state_reg == ST_SCAN);
        issue_ctl.last  = ((CNT_W'(addr_reg) + CNT_W'(1)) == n_reg);
    end

    // The first distance of a scan always wins; later ones only when strictly
    // smaller, which keeps the lowest slot on a tie.
    assign dist_better = (cmp_idx_reg == '0) || (dist_sq < best_reg);
    assign out_free    = !res_valid_reg || result.ready;

    nps_store #(
        .DEPTH  (MAX_POINTS),
        .WIDTH  (3 * COORD_BITS),
        .ADDR_W (ADDR_W)
    ) u_store (
        .clk   (clk),
        .we    (load_we),
        .waddr (ADDR_W'(item.slot)),
        .wdata ({item.coord_x, item.coord_y, item.coord_z}),
        .re    (issue_ctl.valid),
        .raddr (addr_reg),
        .rdata (rdata)
    );

    nps_dist_unit #(
        .COORD_BITS (COORD_BITS)
    ) u_dist (
        .clk       (clk),
        .rst_n     (rst_n),
        .query_x   (qx_reg),
        .query_y   (qy_reg),
        .query_z   (qz_reg),
        .issue_ctl (issue_ctl),
        .point     (rdata),
        .dist_ctl  (dist_ctl),
        .dist_sq   (dist_sq)
    );

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            point_count_reg <= '0;
            limit_reg       <= LIMIT_RESET;
        end
        else if (wr_en)
        begin
            unique case (reg_index)
                REG_POINT_COUNT: point_count_reg <= wr_data[COUNT_W-1:0];
                REG_MAX_DIST:    limit_reg       <= wr_data[DIST_W-1:0];
                default:         ;
            endcase
        end
    end

    // Sequencer, running minimum and output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            qx_reg         <= '0;
            qy_reg         <= '0;
            qz_reg         <= '0;
            tag_reg        <= '0;
            n_reg          <= '0;
            addr_reg       <= '0;
            cmp_idx_reg    <= '0;
            best_reg       <= '0;
            best_idx_reg   <= '0;
            empty_reg      <= 1'b0;
            res_valid_reg  <= 1'b0;
            res_tag_reg    <= '0;
            res_slot_reg   <= '0;
            res_dist_reg   <= '0;
            res_within_reg <= 1'b0;
            res_empty_reg  <= 1'b0;
        end
        else
        begin
            // A finishing query refills the output register in the same cycle.
            if (result.valid && result.ready && (state_reg != ST_FINISH))
            begin
                res_valid_reg <= 1'b0;
            end

            if (dist_ctl.valid)
            begin
                cmp_idx_reg <= cmp_idx_reg + ADDR_W'(1);
                if (dist_better)
                begin
                    best_reg     <= dist_sq;
                    best_idx_reg <= cmp_idx_reg;
                end
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (item_fire && (item.opcode == OP_QUERY))
                    begin
                        qx_reg       <= item.coord_x;
                        qy_reg       <= item.coord_y;
                        qz_reg       <= item.coord_z;
                        tag_reg      <= item.query_tag;
                        n_reg        <= n_clamped;
                        addr_reg     <= '0;
                        cmp_idx_reg  <= '0;
                        best_reg     <= DIST_MAX;
                        best_idx_reg <= '0;
                        empty_reg    <= (n_clamped == '0);
                        state_reg    <= (n_clamped == '0) ? ST_FINISH : ST_SCAN;
                    end
                end
                ST_SCAN:
                begin
                    addr_reg <= addr_reg + ADDR_W'(1);
                    if (issue_ctl.last)
                    begin
                        state_reg <= ST_DRAIN;
                    end
                end
                ST_DRAIN:
                begin
                    if (dist_ctl.valid && dist_ctl.last)
                    begin
                        state_reg <= ST_FINISH;
                    end
                end
                ST_FINISH:
                begin
                    if (out_free)
                    begin
                        res_valid_reg  <= 1'b1;
                        res_tag_reg    <= tag_reg;
                        res_slot_reg   <= SLOT_W'(best_idx_reg);
                        res_dist_reg   <= best_reg;
                        res_within_reg <= !empty_reg && (best_reg <= limit_reg);
                        res_empty_reg  <= empty_reg;
                        state_reg      <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign result.valid            = res_valid_reg;
    assign result.tag_out          = res_tag_reg;
    assign result.nearest_slot     = res_slot_reg;
    assign result.best_distance_sq = res_dist_reg;
    assign result.within_limit     = res_within_reg;
    assign result.store_empty      = res_empty_reg;

    // Distances come out of the pipeline only while a scan is in progress.
    a_dist_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        dist_ctl.valid |-> (state_reg == ST_SCAN || state_reg == ST_DRAIN))
        else $error("distance produced outside a scan");

    // The scan never reads past the clamped point count.
    a_addr_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (CNT_W'(addr_reg) < n_reg))
        else $error("scan address beyond point count");

    // An empty store is never reported as a match within the limit.
    a_empty_no_match: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.store_empty) |-> !result.within_limit)
        else $error("empty store flagged within limit");

    // A finished query reaches the output register as soon as it is free.
    a_finish_loads: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FINISH && out_free) |=> (result.valid && state_reg == ST_IDLE))
        else $error("finished result not loaded");

endmodule

`default_nettype wire

// File: sim/nps_search_checker.sv
// ----------------------------------------------------------------------------
// nps_search_checker
// Watches the item, result and register ports of the nearest point search
// block, keeps its own copy of the point store and the two registers, works
// out the answer of every query and compares each result transfer with it.
// ----------------------------------------------------------------------------
module nps_search_checker
    import nps_pkg::*;
#(
    parameter int MAX_POINTS = DEF_MAX_POINTS,
    parameter int COORD_BITS = DEF_COORD_BITS
) (
    input  logic                    clk,
    input  logic                    rst_n,
    nps_item_if                     item_mon,
    nps_result_if                   result_mon,
    input  logic                    wr_en,
    input  logic [REG_INDEX_W-1:0]  reg_index,
    input  logic [2*COORD_BITS+1:0] wr_data,
    output int                      fail_count,
    output int                      answers_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int     DIST_W         = 2*COORD_BITS + 2;
    localparam longint COORD_SPAN     = (longint'(1) << COORD_BITS) - 1;
    localparam longint DIST_CEILING   = 3 * COORD_SPAN * COORD_SPAN;
    localparam longint LIMIT_AT_RESET = 429497;

    typedef struct packed {
        logic [TAG_W-1:0]  tag;
        logic [SLOT_W-1:0] slot;
        logic [DIST_W-1:0] dist_sq;
        logic              in_limit;
        logic              empty;
    } nps_answer_t;

    logic signed [COORD_BITS-1:0] tgt_x [MAX_POINTS];
    logic signed [COORD_BITS-1:0] tgt_y [MAX_POINTS];
    logic signed [COORD_BITS-1:0] tgt_z [MAX_POINTS];
    logic [COUNT_W-1:0]           cfg_count;
    logic [DIST_W-1:0]            cfg_limit;
    nps_answer_t                  answers_due [$];
    int                           mismatches = 0;

    assign fail_count = mismatches;

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        mismatches++;
    endtask

    // Linear scan over the active slots; a strictly smaller distance is
    // needed to replace the current best, so ties keep the lowest slot.
    function automatic nps_answer_t nearest_answer(
        input logic signed [COORD_BITS-1:0] qx,
        input logic signed [COORD_BITS-1:0] qy,
        input logic signed [COORD_BITS-1:0] qz,
        input logic [TAG_W-1:0]             tag
    );
        nps_answer_t ans;
        longint      n;
        longint      best;
        longint      d;
        longint      dx;
        longint      dy;
        longint      dz;
        int          best_slot;
        int          i;
        bit          found;
        n         = (cfg_count > MAX_POINTS) ? MAX_POINTS : cfg_count;
        best      = DIST_CEILING;
        best_slot = 0;
        found     = 1'b0;
        for (i = 0; i < n; i++)
        begin
            dx = longint'(qx) - longint'(tgt_x[i]);
            dy = longint'(qy) - longint'(tgt_y[i]);
            dz = longint'(qz) - longint'(tgt_z[i]);
            d  = dx*dx + dy*dy + dz*dz;
            if (!found || d < best)
            begin
                best      = d;
                best_slot = i;
                found     = 1'b1;
            end
        end
        ans.tag      = tag;
        ans.slot     = best_slot[SLOT_W-1:0];
        ans.dist_sq  = best[DIST_W-1:0];
        ans.in_limit = found && (best <= longint'(cfg_limit));
        ans.empty    = !found;
        return ans;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        nps_answer_t want;
        if (!rst_n)
        begin
            cfg_count = '0;
            cfg_limit = LIMIT_AT_RESET[DIST_W-1:0];
            answers_due.delete();
            answers_pending <= 0;
        end
        else
        begin
            if (wr_en)
            begin
                if (reg_index == REG_POINT_COUNT)
                    cfg_count = wr_data[COUNT_W-1:0];
                else if (reg_index == REG_MAX_DIST)
                    cfg_limit = wr_data[DIST_W-1:0];
            end

            // A result always belongs to an older query, so retire first.
            if (result_mon.valid && result_mon.ready)
            begin
                if (answers_due.size() == 0)
                    report_mismatch($sformatf("result with tag %h and no query waiting",
                                              result_mon.tag_out));
                else
                begin
                    want = answers_due.pop_front();
                    if (result_mon.tag_out != want.tag)
                        report_mismatch($sformatf("tag_out %h, want %h",
                                                  result_mon.tag_out, want.tag));
                    if (result_mon.nearest_slot != want.slot)
                        report_mismatch($sformatf("tag %h nearest_slot %0d, want %0d",
                                                  want.tag, result_mon.nearest_slot,
                                                  want.slot));
                    if (result_mon.best_distance_sq != want.dist_sq)
                        report_mismatch($sformatf("tag %h best_distance_sq %0d, want %0d",
                                                  want.tag, result_mon.best_distance_sq,
                                                  want.dist_sq));
                    if (result_mon.within_limit != want.in_limit)
                        report_mismatch($sformatf("tag %h within_limit %b, want %b",
                                                  want.tag, result_mon.within_limit,
                                                  want.in_limit));
                    if (result_mon.store_empty != want.empty)
                        report_mismatch($sformatf("tag %h store_empty %b, want %b",
                                                  want.tag, result_mon.store_empty,
                                                  want.empty));
                end
            end

            if (item_mon.valid && item_mon.ready)
            begin
                if (item_mon.opcode == OP_LOAD)
                begin
                    if (item_mon.slot < MAX_POINTS)
                    begin
                        tgt_x[item_mon.slot] = item_mon.coord_x;
                        tgt_y[item_mon.slot] = item_mon.coord_y;
                        tgt_z[item_mon.slot] = item_mon.coord_z;
                    end
                end
                else
                    answers_due.insert(answers_due.size(),
                                       nearest_answer(item_mon.coord_x, item_mon.coord_y,
                                                      item_mon.coord_z,
                                                      item_mon.query_tag));
            end

            answers_pending <= answers_due.size();
        end
    end

endmodule

// File: sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// Top of the nearest point search testbench. It drives load and query
// transfers and register writes into the block, stalls the result side at
// random, and leaves all prediction and comparison to the checker beside
// the block. A watchdog ends the run when the ports go quiet for too long.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import nps_pkg::*;

    localparam int HALF_PERIOD    = 10;
    localparam int RESET_CYCLES   = 9;
    localparam int RANDOM_ITEMS   = 300;
    localparam int MAX_GAP        = 7;
    localparam int DIST_W         = 2*DEF_COORD_BITS + 2;
    // Slots written before the random part; counts never reach past them.
    localparam int FILL_SLOTS     = 128;
    // Loads finish at their transfer; this pause covers one still in flight when
    // the last expected result has come back.
    localparam int SETTLE_CYCLES  = 16;
    // A full scan reads all MAX_POINTS slots, and this window is longer, so a
    // stray result would show up within this window.
    localparam int DRAIN_CYCLES   = DEF_MAX_POINTS + 76;
    // The slowest correct stretch with no transfer is one full scan plus
    // the longest stall on either side; the limit is several times that.
    localparam int WATCHDOG_LIMIT = 8 * DEF_MAX_POINTS;

    typedef logic signed [DEF_COORD_BITS-1:0] coord_t;

    localparam coord_t            C_MIN        = coord_t'(-32768);
    localparam coord_t            C_MAX        = coord_t'(32767);
    localparam coord_t            C_ZERO       = coord_t'(0);
    localparam logic [SLOT_W-1:0] SLOT_TOP     = '1;
    localparam logic [DIST_W-1:0] DIST_CEILING = 34'd12884508675;
    localparam logic [DIST_W-1:0] LIMIT_RESET  = 34'd429497;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   wr_en;
    logic [REG_INDEX_W-1:0] reg_index;
    logic [DIST_W-1:0]      wr_data;
    int                     fail_count;
    int                     answers_pending;
    int                     quiet_cycles = 0;
    // When set, neither side idles: back-to-back transfers.
    bit                     fast_lane = 1'b0;

    // Copy of the store contents, used only to aim queries near real points.
    coord_t shadow_x [DEF_MAX_POINTS];
    coord_t shadow_y [DEF_MAX_POINTS];
    coord_t shadow_z [DEF_MAX_POINTS];

    nps_item_if   item_ch ();
    nps_result_if result_ch ();

    nearest_point_search_3d u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item_ch),
        .result    (result_ch),
        .wr_en     (wr_en),
        .reg_index (reg_index),
        .wr_data   (wr_data)
    );

    nps_search_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .item_mon        (item_ch),
        .result_mon      (result_ch),
        .wr_en           (wr_en),
        .reg_index       (reg_index),
        .wr_data         (wr_data),
        .fail_count      (fail_count),
        .answers_pending (answers_pending)
    );

    always
    begin
        #(HALF_PERIOD) clk = 1'b1;
        #(HALF_PERIOD) clk = 1'b0;
    end

    // Any transfer on either channel, or a register write, counts as progress.
    always @(posedge clk)
    begin
        if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready) || wr_en)
            quiet_cycles = 0;
        else
            quiet_cycles = quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic int draw_gap();
        return fast_lane ? 0 : $urandom_range(0, MAX_GAP);
    endfunction

    // Coordinates lean on the two ends of the range and on zero.
    function automatic coord_t rand_coord();
        case ($urandom_range(0, 9))
            0:       return C_MIN;
            1:       return C_MAX;
            2:       return C_ZERO;
            default: return coord_t'($urandom);
        endcase
    endfunction

    // Moves a coordinate by a few hundred LSBs, which keeps the squared
    // distance in the neighborhood of the default limit.
    function automatic coord_t nudge(input coord_t c);
        int v;
        v = int'(c) + int'($urandom_range(0, 1200)) - 600;
        if (v > 32767)
            v = 32767;
        if (v < -32768)
            v = -32768;
        return coord_t'(v);
    endfunction

    // Presents one item and returns right after the edge that transfers it.
    // Valid is lowered only when a gap follows, so it never gets two
    // assignments in the same time step.
    task automatic send_item(
        input logic              op,
        input logic [SLOT_W-1:0] slot,
        input coord_t            x,
        input coord_t            y,
        input coord_t            z,
        input logic [TAG_W-1:0]  tag
    );
        int gap;
        gap = draw_gap();
        if (gap > 0)
        begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_ch.valid     <= 1'b1;
        item_ch.opcode    <= op;
        item_ch.slot      <= slot;
        item_ch.coord_x   <= x;
        item_ch.coord_y   <= y;
        item_ch.coord_z   <= z;
        item_ch.query_tag <= tag;
        @(posedge clk);
        while (!item_ch.ready)
            @(posedge clk);
    endtask

    // The tag of a load and the slot of a query are ignored by the block,
    // so they carry random bits.
    task automatic load_point(input logic [SLOT_W-1:0] slot, input coord_t x,
                              input coord_t y, input coord_t z);
        shadow_x[slot] = x;
        shadow_y[slot] = y;
        shadow_z[slot] = z;
        send_item(OP_LOAD, slot, x, y, z, TAG_W'($urandom));
    endtask

    task automatic query_point(input coord_t x, input coord_t y, input coord_t z,
                               input logic [TAG_W-1:0] tag);
        send_item(OP_QUERY, SLOT_W'($urandom), x, y, z, tag);
    endtask

    // Brings the block to idle: no item offered, every answer back, and a
    // short pause for a load that might still be in progress.
    task automatic settle();
        item_ch.valid <= 1'b0;
        @(posedge clk);
        while (answers_pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Writes count then limit, back to back; only called after settle.
    task automatic write_config(input logic [DIST_W-1:0] count_word,
                                input logic [DIST_W-1:0] limit_word);
        wr_en     <= 1'b1;
        reg_index <= REG_POINT_COUNT;
        wr_data   <= count_word;
        @(posedge clk);
        reg_index <= REG_MAX_DIST;
        wr_data   <= limit_word;
        @(posedge clk);
        wr_en     <= 1'b0;
    endtask

    // Result side: before each result the receiver stalls for a drawn
    // number of cycles, then holds ready high until a transfer happens.
    initial
    begin
        int stall;
        result_ch.ready <= 1'b0;
        @(posedge clk);
        forever
        begin
            stall = draw_gap();
            if (stall > 0)
            begin
                result_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            result_ch.ready <= 1'b1;
            @(posedge clk);
            while (!result_ch.valid)
                @(posedge clk);
        end
    end

    initial
    begin
        int                count_val;
        int                n_active;
        int                items_here;
        int                sent;
        int                phase;
        int                k;
        int                s;
        logic [DIST_W-1:0] count_word;
        logic [DIST_W-1:0] limit_word;

        rst_n             <= 1'b0;
        wr_en             <= 1'b0;
        reg_index         <= REG_POINT_COUNT;
        wr_data           <= '0;
        item_ch.valid     <= 1'b0;
        item_ch.opcode    <= OP_LOAD;
        item_ch.slot      <= '0;
        item_ch.coord_x   <= '0;
        item_ch.coord_y   <= '0;
        item_ch.coord_z   <= '0;
        item_ch.query_tag <= '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ---------------------------------------------------------------
        // Directed part.
        // ---------------------------------------------------------------
        // Right after reset the count is zero, so both queries see an
        // empty store: slot 0, the largest distance, never within limit.
        query_point(C_ZERO, C_ZERO, C_ZERO, 16'hFFFF);
        query_point(C_MAX, C_MIN, C_MAX, 16'h0000);

        // Opposite corners, the origin, a duplicate of slot 1 for the tie
        // rule, and the top slot of the store.
        load_point(10'd0, C_MIN, C_MIN, C_MIN);
        load_point(10'd1, C_MAX, C_MAX, C_MAX);
        load_point(10'd2, C_ZERO, C_ZERO, C_ZERO);
        load_point(10'd3, C_MAX, C_MAX, C_MAX);
        load_point(SLOT_TOP, coord_t'(100), coord_t'(-100), coord_t'(5));

        // Equal distances to slots 1 and 3 must report slot 1.
        settle();
        write_config(34'd4, DIST_CEILING);
        query_point(C_MAX, C_MAX, C_MAX, 16'h1234);
        query_point(C_MIN, C_MIN, C_MIN, 16'hA5A5);
        query_point(coord_t'(1), coord_t'(-1), coord_t'(2), 16'h5A5A);

        // Corner to corner is the largest distance there is; a limit equal
        // to it passes, one below it does not.
        settle();
        write_config(34'd1, DIST_CEILING);
        query_point(C_MAX, C_MAX, C_MAX, 16'h0F0F);
        settle();
        write_config(34'd1, DIST_CEILING - 34'd1);
        query_point(C_MAX, C_MAX, C_MAX, 16'hF0F0);

        // With a zero limit only an exact hit counts as within limit.
        settle();
        write_config(34'd3, '0);
        query_point(C_ZERO, C_ZERO, C_ZERO, 16'h0001);
        query_point(coord_t'(1), C_ZERO, C_ZERO, 16'h8000);

        // ---------------------------------------------------------------
        // Fill the low slots so that every count used below only ever
        // reads written entries.
        // ---------------------------------------------------------------
        settle();
        for (k = 0; k < FILL_SLOTS; k++)
        begin
            if (k % 64 == 0)
                fast_lane = ($urandom_range(0, 1) == 0);
            load_point(SLOT_W'(k), rand_coord(), rand_coord(), rand_coord());
        end

        // ---------------------------------------------------------------
        // Random phases. Each one picks a count within the filled slots and
        // a limit, then mixes loads with queries, most of them aimed near an
        // active point so that the limit flag goes both ways.
        // ---------------------------------------------------------------
        sent  = 0;
        phase = 0;
        while (sent < RANDOM_ITEMS)
        begin
            fast_lane = ($urandom_range(0, 3) == 0);
            case (phase)
                1:       count_val = 0;
                2:       count_val = FILL_SLOTS;
                default:
                begin
                    s = $urandom_range(0, 9);
                    if (s == 0)
                        count_val = $urandom_range(0, 1);
                    else if (s < 7)
                        count_val = $urandom_range(1, 16);
                    else
                        count_val = $urandom_range(17, FILL_SLOTS);
                end
            endcase
            // The upper bits of a count write are dropped by the register.
            count_word                = DIST_W'({$urandom, $urandom});
            count_word[COUNT_W-1:0]   = COUNT_W'(count_val);

            case ($urandom_range(0, 6))
                0:       limit_word = '0;
                1:       limit_word = DIST_CEILING;
                2:       limit_word = '1;
                3:       limit_word = LIMIT_RESET;
                4:       limit_word = DIST_W'($urandom_range(0, 1 << 22));
                default: limit_word = DIST_W'({$urandom, $urandom});
            endcase
            // An empty store must stay out of limit even at the widest limit.
            if (phase == 1)
                limit_word = '1;

            n_active   = (count_val > DEF_MAX_POINTS) ? DEF_MAX_POINTS : count_val;
            items_here = 40;

            settle();
            write_config(count_word, limit_word);
            for (k = 0; k < items_here; k++)
            begin
                if ($urandom_range(0, 9) < 3)
                    load_point(SLOT_W'($urandom), rand_coord(), rand_coord(), rand_coord());
                else if (n_active > 0 && $urandom_range(0, 9) < 6)
                begin
                    s = $urandom_range(0, n_active - 1);
                    query_point(nudge(shadow_x[s]), nudge(shadow_y[s]), nudge(shadow_z[s]),
                                TAG_W'($urandom));
                end
                else
                    query_point(rand_coord(), rand_coord(), rand_coord(), TAG_W'($urandom));
            end
            sent  = sent + items_here;
            phase = phase + 1;
        end

        // Wait for every answer, then long enough for a stray one to show.
        settle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
